// ===== hw/rtl/http_chunked_body_decoder_defines.svh =====
// Assertion macros for the chunked body decoder checker.
`ifndef HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CHBD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CHBD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/chbd_pkg.sv =====
// Shared constants, types and the hex digit decoder of the chunked body decoder.
package chbd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned PHASE_W = 4;

  localparam logic [PHASE_W-1:0] PH_SIZE    = 4'd0;
  localparam logic [PHASE_W-1:0] PH_EXT     = 4'd1;
  localparam logic [PHASE_W-1:0] PH_SIZE_CR = 4'd2;
  localparam logic [PHASE_W-1:0] PH_EXT_CR  = 4'd3;
  localparam logic [PHASE_W-1:0] PH_DATA    = 4'd4;
  localparam logic [PHASE_W-1:0] PH_DSKIP1  = 4'd5;
  localparam logic [PHASE_W-1:0] PH_DSKIP2  = 4'd6;
  localparam logic [PHASE_W-1:0] PH_ZSKIP1  = 4'd7;
  localparam logic [PHASE_W-1:0] PH_ZSKIP2  = 4'd8;
  localparam logic [PHASE_W-1:0] PH_DONE    = 4'd9;
  localparam logic [PHASE_W-1:0] PH_ERR     = 4'd10;

  localparam logic [KIND_W-1:0] K_FRAME   = 3'd0;
  localparam logic [KIND_W-1:0] K_PAYLOAD = 3'd1;
  localparam logic [KIND_W-1:0] K_DONE    = 3'd2;
  localparam logic [KIND_W-1:0] K_ERROR   = 3'd3;
  localparam logic [KIND_W-1:0] K_IGNORED = 3'd4;

  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_LA    = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LF_HX = 8'h66;
  localparam logic [BYTE_W-1:0] CH_UA    = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UF_HX = 8'h46;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [BYTE_W-1:0] c);
    hex_t        h;
    logic [BYTE_W-1:0] t;
    h = '0;
    t = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      t     = c - CH_ZERO;
      h.ok  = 1'b1;
      h.val = t[3:0];
    end else if (c >= CH_LA && c <= CH_LF_HX) begin
      t     = c - CH_LA + 8'd10;
      h.ok  = 1'b1;
      h.val = t[3:0];
    end else if (c >= CH_UA && c <= CH_UF_HX) begin
      t     = c - CH_UA + 8'd10;
      h.ok  = 1'b1;
      h.val = t[3:0];
    end
    return h;
  endfunction

endpackage

// ===== hw/rtl/http_chunked_body_decoder.sv =====
// Each input beat is held in the input reg, then its result in the result reg.
// Throughput: one byte per cycle unless stalled; chbd_step's state update sets it.
// in_tready stays high while the result register is empty or being drained.
// Reset (rst_n low, synchronous) empties both registers and returns the parser
// to the start of a size line.
module http_chunked_body_decoder #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] byte_in
  input  logic       in_tuser,   // [0] restart
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] payload
  output logic [2:0] out_tuser,  // [2:0] kind
  output logic       out_tlast
);

  logic                         in_valid_r;
  logic [chbd_pkg::BYTE_W-1:0]  in_byte_r;
  logic                         in_restart_r;
  logic                         out_valid_r;
  logic [chbd_pkg::BYTE_W-1:0]  out_payload_r;
  logic [chbd_pkg::KIND_W-1:0]  out_kind_r;
  logic                         out_last_r;
  logic [chbd_pkg::PHASE_W-1:0] phase_r;
  logic [chbd_pkg::PHASE_W-1:0] phase_nxt;
  logic [SIZE_BITS-1:0]         size_r;
  logic [SIZE_BITS-1:0]         size_nxt;
  logic                         seen_r;
  logic                         seen_nxt;
  logic [SIZE_BITS-1:0]         rem_r;
  logic [SIZE_BITS-1:0]         rem_nxt;
  logic [chbd_pkg::KIND_W-1:0]  kind_nxt;
  logic [chbd_pkg::BYTE_W-1:0]  payload_nxt;
  logic                         last_nxt;
  logic                         advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  chbd_step #(
    .SIZE_BITS(SIZE_BITS)
  ) u_step (
    .phase         (phase_r),
    .size_accum    (size_r),
    .digit_seen    (seen_r),
    .remaining     (rem_r),
    .byte_in       (in_byte_r),
    .restart       (in_restart_r),
    .phase_nxt     (phase_nxt),
    .size_accum_nxt(size_nxt),
    .digit_seen_nxt(seen_nxt),
    .remaining_nxt (rem_nxt),
    .kind          (kind_nxt),
    .payload       (payload_nxt),
    .chunk_last    (last_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= chbd_pkg::PH_SIZE;
      size_r      <= '0;
      seen_r      <= 1'b0;
      rem_r       <= '0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        phase_r     <= phase_nxt;
        size_r      <= size_nxt;
        seen_r      <= seen_nxt;
        rem_r       <= rem_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r    <= in_tdata;
      in_restart_r <= in_tuser;
    end
    if (advance) begin
      out_payload_r <= payload_nxt;
      out_kind_r    <= kind_nxt;
      out_last_r    <= last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_payload_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== hw/rtl/chbd_step.sv =====
// Next-state and result logic for one body byte.
module chbd_step #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  logic [chbd_pkg::PHASE_W-1:0] phase,
  input  logic [SIZE_BITS-1:0]         size_accum,
  input  logic                         digit_seen,
  input  logic [SIZE_BITS-1:0]         remaining,
  input  logic [chbd_pkg::BYTE_W-1:0]  byte_in,
  input  logic                         restart,
  output logic [chbd_pkg::PHASE_W-1:0] phase_nxt,
  output logic [SIZE_BITS-1:0]         size_accum_nxt,
  output logic                         digit_seen_nxt,
  output logic [SIZE_BITS-1:0]         remaining_nxt,
  output logic [chbd_pkg::KIND_W-1:0]  kind,
  output logic [chbd_pkg::BYTE_W-1:0]  payload,
  output logic                         chunk_last
);

  logic [chbd_pkg::PHASE_W-1:0] ph;
  logic [SIZE_BITS-1:0]         sz;
  logic                         seen;
  logic [SIZE_BITS-1:0]         rem;
  logic [SIZE_BITS-1:0]         rem_dec;
  chbd_pkg::hex_t               hx;
  logic                         sz_full;

  always_comb begin
    ph   = restart ? chbd_pkg::PH_SIZE : phase;
    sz   = restart ? '0 : size_accum;
    seen = restart ? 1'b0 : digit_seen;
    rem  = restart ? '0 : remaining;
  end

  assign hx      = chbd_pkg::hex_decode(byte_in);
  assign sz_full = (sz[SIZE_BITS-1 -: 4] != 4'd0);
  assign rem_dec = rem - {{(SIZE_BITS-1){1'b0}}, 1'b1};

  always_comb begin
    phase_nxt      = ph;
    size_accum_nxt = sz;
    digit_seen_nxt = seen;
    remaining_nxt  = rem;
    kind           = chbd_pkg::K_FRAME;
    payload        = '0;
    chunk_last     = 1'b0;
    unique case (ph)
      chbd_pkg::PH_SIZE: begin
        if (byte_in == chbd_pkg::CH_CR) begin
          phase_nxt = chbd_pkg::PH_SIZE_CR;
        end else if (byte_in == chbd_pkg::CH_SEMI) begin
          phase_nxt = chbd_pkg::PH_EXT;
        end else if (!hx.ok || sz_full) begin
          phase_nxt = chbd_pkg::PH_ERR;
          kind      = chbd_pkg::K_ERROR;
        end else begin
          size_accum_nxt = {sz[SIZE_BITS-5:0], hx.val};
          digit_seen_nxt = 1'b1;
        end
      end
      chbd_pkg::PH_EXT: begin
        if (byte_in == chbd_pkg::CH_CR) begin
          phase_nxt = chbd_pkg::PH_EXT_CR;
        end
      end
      chbd_pkg::PH_SIZE_CR, chbd_pkg::PH_EXT_CR: begin
        if (byte_in == chbd_pkg::CH_LF) begin
          if (!seen) begin
            phase_nxt = chbd_pkg::PH_ERR;
            kind      = chbd_pkg::K_ERROR;
          end else if (sz == '0) begin
            phase_nxt = chbd_pkg::PH_ZSKIP1;
          end else begin
            remaining_nxt = sz;
            phase_nxt     = chbd_pkg::PH_DATA;
          end
        end else if (ph == chbd_pkg::PH_SIZE_CR) begin
          phase_nxt = chbd_pkg::PH_ERR;
          kind      = chbd_pkg::K_ERROR;
        end else if (byte_in != chbd_pkg::CH_CR) begin
          phase_nxt = chbd_pkg::PH_EXT;
        end
      end
      chbd_pkg::PH_DATA: begin
        kind          = chbd_pkg::K_PAYLOAD;
        payload       = byte_in;
        remaining_nxt = rem_dec;
        if (rem_dec == '0) begin
          chunk_last = 1'b1;
          phase_nxt  = chbd_pkg::PH_DSKIP1;
        end
      end
      chbd_pkg::PH_DSKIP1: begin
        phase_nxt = chbd_pkg::PH_DSKIP2;
      end
      chbd_pkg::PH_DSKIP2: begin
        phase_nxt      = chbd_pkg::PH_SIZE;
        size_accum_nxt = '0;
        digit_seen_nxt = 1'b0;
      end
      chbd_pkg::PH_ZSKIP1: begin
        phase_nxt = chbd_pkg::PH_ZSKIP2;
      end
      chbd_pkg::PH_ZSKIP2: begin
        phase_nxt = chbd_pkg::PH_DONE;
        kind      = chbd_pkg::K_DONE;
      end
      default: begin
        kind = chbd_pkg::K_IGNORED;
      end
    endcase
  end

endmodule

// ===== hw/rtl/chbd_checker.sv =====
// Port-level checker for the chunked body decoder, bound to the top level.
`include "http_chunked_body_decoder_defines.svh"

module chbd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       in_tuser,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [2:0] out_tuser,
  input logic       out_tlast
);

  logic        out_stall;
  logic        in_stall;
  logic        non_payload;
  logic        side_clear;
  logic        kind_ok;
  logic [11:0] out_bus;
  logic [8:0]  in_bus;
  logic        idle_accept_r;

  assign out_stall   = out_tvalid && !out_tready;
  assign in_stall    = in_tvalid && !in_tready;
  assign non_payload = out_tvalid && (out_tuser != chbd_pkg::K_PAYLOAD);
  assign side_clear  = (out_tdata == 8'd0) && !out_tlast;
  assign kind_ok     = out_tuser == chbd_pkg::K_FRAME || out_tuser == chbd_pkg::K_PAYLOAD ||
                       out_tuser == chbd_pkg::K_DONE || out_tuser == chbd_pkg::K_ERROR ||
                       out_tuser == chbd_pkg::K_IGNORED;
  assign out_bus     = {out_tlast, out_tuser, out_tdata};
  assign in_bus      = {in_tuser, in_tdata};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_accept_r <= 1'b0;
    end else begin
      idle_accept_r <= in_tvalid && in_tready && !out_tvalid;
    end
  end

  `CHBD_ASSERT_NOW(a_unused_zero, non_payload, side_clear, "non-payload beat carries data")
  `CHBD_ASSERT_NOW(a_kind_range, out_tvalid, kind_ok, "result kind out of range")
  `CHBD_ASSERT_NXT(a_stall_hold, out_stall, out_tvalid && $stable(out_bus), "stalled beat changed")
  `CHBD_ASSERT_NXT(a_in_hold, in_stall, in_tvalid && $stable(in_bus), "waiting input changed")
  `CHBD_ASSERT_NXT(a_beat_out, idle_accept_r, out_tvalid, "accepted beat lost")

endmodule

bind http_chunked_body_decoder chbd_checker u_chbd_checker (.*);

// ===== tb/chunk_body_checker.sv =====
// Chunked body decoder scoreboard: predicts each result beat and compares it.
module chunk_body_checker #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [7:0]        in_tdata,
  input  logic              in_tuser,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [7:0]        out_tdata,
  input  logic [2:0]        out_tuser,
  input  logic              out_tlast,
  output int unsigned       mismatches,
  output int unsigned       outstanding
);

  typedef struct packed {
    logic [chbd_pkg::KIND_W-1:0] kind;
    logic [chbd_pkg::BYTE_W-1:0] payload;
    logic                        last;
  } chunk_beat_t;

  chunk_beat_t                  expected_beats[$];
  chunk_beat_t                  want, got;
  logic [chbd_pkg::PHASE_W-1:0] phase;
  logic [63:0]                  size_acc;
  logic [63:0]                  left_count;
  logic                         have_digit;

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic void clear_parser();
    phase      = chbd_pkg::PH_SIZE;
    size_acc   = '0;
    have_digit = 1'b0;
    left_count = '0;
  endfunction

  function automatic logic [chbd_pkg::KIND_W-1:0] close_line();
    if (!have_digit) begin
      phase = chbd_pkg::PH_ERR;
      return chbd_pkg::K_ERROR;
    end
    if (size_acc == 0) begin
      phase = chbd_pkg::PH_ZSKIP1;
    end else begin
      left_count = size_acc;
      phase      = chbd_pkg::PH_DATA;
    end
    return chbd_pkg::K_FRAME;
  endfunction

  function automatic chunk_beat_t decode_byte(input logic [7:0] b, input logic rs);
    chunk_beat_t r;
    int          d;
    r      = '0;
    r.kind = chbd_pkg::K_FRAME;
    if (rs) clear_parser();
    case (phase)
      chbd_pkg::PH_SIZE: begin
        if (b == chbd_pkg::CH_CR) begin
          phase = chbd_pkg::PH_SIZE_CR;
        end else if (b == chbd_pkg::CH_SEMI) begin
          phase = chbd_pkg::PH_EXT;
        end else begin
          d = hex_digit(b);
          if (d < 0 || (size_acc >> (SIZE_BITS - 4)) != 0) begin
            phase  = chbd_pkg::PH_ERR;
            r.kind = chbd_pkg::K_ERROR;
          end else begin
            size_acc   = {size_acc[59:0], d[3:0]};
            have_digit = 1'b1;
          end
        end
      end
      chbd_pkg::PH_EXT: begin
        if (b == chbd_pkg::CH_CR) phase = chbd_pkg::PH_EXT_CR;
      end
      chbd_pkg::PH_SIZE_CR: begin
        if (b == chbd_pkg::CH_LF) begin
          r.kind = close_line();
        end else begin
          phase  = chbd_pkg::PH_ERR;
          r.kind = chbd_pkg::K_ERROR;
        end
      end
      chbd_pkg::PH_EXT_CR: begin
        if (b == chbd_pkg::CH_LF) r.kind = close_line();
        else if (b != chbd_pkg::CH_CR) phase = chbd_pkg::PH_EXT;
      end
      chbd_pkg::PH_DATA: begin
        r.kind     = chbd_pkg::K_PAYLOAD;
        r.payload  = b;
        left_count = left_count - 64'd1;
        if (left_count == 0) begin
          r.last = 1'b1;
          phase  = chbd_pkg::PH_DSKIP1;
        end
      end
      chbd_pkg::PH_DSKIP1: phase = chbd_pkg::PH_DSKIP2;
      chbd_pkg::PH_DSKIP2: clear_parser();
      chbd_pkg::PH_ZSKIP1: phase = chbd_pkg::PH_ZSKIP2;
      chbd_pkg::PH_ZSKIP2: begin
        phase  = chbd_pkg::PH_DONE;
        r.kind = chbd_pkg::K_DONE;
      end
      default: r.kind = chbd_pkg::K_IGNORED;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_beats.delete();
      clear_parser();
      mismatches  <= 0;
      outstanding <= 0;
    end else begin
      if (in_tvalid && in_tready) expected_beats.push_back(decode_byte(in_tdata, in_tuser));
      if (out_tvalid && out_tready) begin
        got.kind    = out_tuser;
        got.payload = out_tdata;
        got.last    = out_tlast;
        if (expected_beats.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result beat: kind %0d payload %02h last %0b",
                     got.kind, got.payload, got.last);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_beats.pop_front();
          if (want.kind != got.kind || want.payload != got.payload || want.last != got.last) begin
            if (mismatches < 10)
              $display("mismatch: kind %0d/%0d payload %02h/%02h last %0b/%0b (exp/act)",
                       want.kind, got.kind, want.payload, got.payload, want.last, got.last);
            mismatches <= mismatches + 1;
          end
        end
      end
      outstanding <= expected_beats.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Chunked body decoder testbench top: clock, reset, byte stimulus and verdict.
module tb_top;

  localparam int unsigned DEC_SIZE_BITS = 32;
  localparam int unsigned ITEM_GOAL     = 1900;

  localparam int RX_OPEN     = 0;
  localparam int RX_LIGHT    = 1;
  localparam int RX_HEAVY    = 2;
  localparam int RX_PERIODIC = 3;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = '0;
  logic       in_tuser   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [2:0] out_tuser;
  logic       out_tlast;

  int unsigned mismatches;
  int unsigned outstanding;

  int          burst_left = 0;
  int unsigned sent       = 0;
  int          rx_mode    = RX_OPEN;
  int          rx_left    = 0;
  int unsigned rx_tick    = 0;
  logic [7:0]  msg_q[$];

  http_chunked_body_decoder #(.SIZE_BITS(DEC_SIZE_BITS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  chunk_body_checker #(.SIZE_BITS(DEC_SIZE_BITS)) checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  always @(negedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_left == 0) begin
      rx_mode = $urandom_range(RX_OPEN, RX_PERIODIC);
      rx_left = $urandom_range(32, 200);
    end else begin
      rx_left = rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:  out_tready <= 1'b1;
      RX_LIGHT: out_tready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY: out_tready <= ($urandom_range(0, 3) == 0);
      default:  out_tready <= (rx_tick % 5 != 0);
    endcase
  end

  task automatic send_item(input logic [7:0] b, input logic rs);
    if (burst_left <= 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= rs;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    sent++;
  endtask

  task automatic send_msg(input bit first_restart);
    foreach (msg_q[i]) begin
      if (i == 0) send_item(msg_q[i], first_restart);
      else send_item(msg_q[i], $urandom_range(0, 149) == 0);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) msg_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] random_case(input logic [7:0] c);
    if (c >= "a" && c <= "f" && $urandom_range(0, 1) == 1) return c - 8'd32;
    return c;
  endfunction

  task automatic push_size_line(input int unsigned size);
    string s;
    int    k;
    s = $sformatf("%0h", size);
    k = ($urandom_range(0, 15) == 0) ? 10 :
        ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (k) msg_q.push_back(chbd_pkg::CH_ZERO);
    for (int i = 0; i < s.len(); i++) msg_q.push_back(random_case(s[i]));
    if ($urandom_range(0, 3) == 0) begin
      msg_q.push_back(chbd_pkg::CH_SEMI);
      repeat ($urandom_range(0, 5)) begin
        if ($urandom_range(0, 4) == 0) begin
          msg_q.push_back(chbd_pkg::CH_CR);
        end else begin
          k = $urandom_range(0, 255);
          msg_q.push_back((k == chbd_pkg::CH_LF) ? 8'hFF : k[7:0]);
        end
      end
    end
    msg_q.push_back(chbd_pkg::CH_CR);
    msg_q.push_back(chbd_pkg::CH_LF);
  endtask

  task automatic push_trailer();
    if ($urandom_range(0, 7) == 0) begin
      msg_q.push_back(8'($urandom_range(0, 255)));
      msg_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      msg_q.push_back(chbd_pkg::CH_CR);
      msg_q.push_back(chbd_pkg::CH_LF);
    end
  endtask

  task automatic make_message();
    string       digits;
    int unsigned size;
    int unsigned pos;
    digits = "0123456789abcdefABCDEF";
    msg_q.delete();
    repeat ($urandom_range(1, 4)) begin
      size = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
      push_size_line(size);
      repeat (size) msg_q.push_back(8'($urandom_range(0, 255)));
      push_trailer();
    end
    push_size_line(0);
    push_trailer();
    repeat ($urandom_range(0, 2)) msg_q.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 99) < 25) begin
      case ($urandom_range(0, 3))
        0: begin
          pos = $urandom_range(0, msg_q.size() - 1);
          msg_q[pos] = 8'($urandom_range(0, 255));
        end
        1: begin
          pos = $urandom_range(1, msg_q.size());
          while (msg_q.size() > pos) void'(msg_q.pop_back());
        end
        2: begin
          msg_q.delete();
          repeat ($urandom_range(1, 12)) msg_q.push_back(8'($urandom_range(0, 255)));
        end
        default: begin
          msg_q.delete();
          msg_q.push_back(digits[$urandom_range(1, 21)]);
          repeat ($urandom_range(8, 10)) msg_q.push_back(digits[$urandom_range(0, 21)]);
          push_text("\r\n");
        end
      endcase
    end
  endtask

  initial begin
    int unsigned msg_count;
    int unsigned wait_cycles;
    msg_count = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    msg_q.delete();
    push_text("2;\rz\r\n");
    msg_q.push_back(8'h00);
    msg_q.push_back(8'hFF);
    push_text("\r\n0\r\n\r\nx");
    send_msg(1'b1);
    msg_q.delete();
    push_text(";\r\n");
    send_msg(1'b1);
    msg_q.delete();
    push_text("\rX");
    send_msg(1'b1);
    msg_q.delete();
    push_text("G");
    send_msg(1'b1);
    msg_q.delete();
    push_text("fFfFfFfFf.");
    send_msg(1'b1);
    drain();

    while (sent < ITEM_GOAL) begin
      make_message();
      send_msg($urandom_range(0, 7) != 0);
      msg_count++;
      if (msg_count % 17 == 8) drain();
    end

    in_tvalid <= 1'b0;
    wait_cycles = 0;
    while (outstanding != 0 && wait_cycles < 20000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (8) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== http_chunked_body_decoder.f =====
+incdir+hw/rtl
hw/rtl/chbd_pkg.sv
hw/rtl/chbd_step.sv
hw/rtl/http_chunked_body_decoder.sv
hw/rtl/chbd_checker.sv
tb/chunk_body_checker.sv
tb/tb_top.sv
